[rtl/ab64d_pkg.sv]
// Package for the armored Base64 stream decoder.
// Holds payload and queue entry types, constants and the sextet decoder.
// No dependencies.
package ab64d_pkg;

   localparam int unsigned LINE_LIMIT = 253;
   localparam int unsigned QDEPTH     = 4;
   localparam int unsigned QPTR_W     = $clog2(QDEPTH);
   localparam int unsigned QCNT_W     = $clog2(QDEPTH + 1);

   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_LF   = 8'h0A;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [31:0] byte_index;
      logic        is_armored;
      logic        last_of_run;
   } rsp_type;

   // one queue word: one or two bytes, pushed for one accepted input word
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic       two;
      logic       armored;
   } entry_type;

   typedef struct packed {
      logic ready;
      logic not_empty;
   } qstat_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet(input logic [7:0] c);
      sextet_type r;
      r.hit   = 1'b1;
      r.value = 6'd0;
      if (c inside {[8'h41:8'h5A]}) begin
         r.value = 6'(c - 8'h41);
      end else if (c inside {[8'h61:8'h7A]}) begin
         r.value = 6'(c - 8'h61 + 8'd26);
      end else if (c inside {[8'h30:8'h39]}) begin
         r.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         r.value = 6'd62;
      end else if (c == 8'h2F) begin
         r.value = 6'd63;
      end else begin
         r.hit = 1'b0;
      end
      return r;
   endfunction

endpackage

[rtl/ab64d_front.sv]
// Front end: accepts input words, tracks mode and header lines, decodes Base64.
// Pushes produced bytes into the queue. Depends on ab64d_pkg.
module ab64d_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ab64d_pkg::req_type  req_data,
   input  logic                q_ready,
   output logic                q_push,
   output ab64d_pkg::entry_type q_entry
);
   import ab64d_pkg::*;

   typedef enum logic [5:0] {
      PH_FIRST  = 6'b000001,
      PH_SECOND = 6'b000010,
      PH_PASS   = 6'b000100,
      PH_HEADER = 6'b001000,
      PH_DECODE = 6'b010000,
      PH_HALT   = 6'b100000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] held_ff, held_in;
   logic [7:0] line_len_ff, line_len_in;
   logic [5:0] bit_buf_ff, bit_buf_in;
   logic [2:0] bit_cnt_ff, bit_cnt_in;

   logic       accept;
   logic [7:0] c;
   sextet_type sx;
   logic [11:0] acc;
   logic [3:0]  cnt;
   logic [3:0]  cnt_out;
   logic [11:0] mask;

   assign req_ready = q_ready;
   assign accept    = req_valid && q_ready;
   assign c         = req_data.in_byte;
   assign sx        = sextet(c);
   assign acc       = {bit_buf_ff, sx.value};
   assign cnt       = {1'b0, bit_cnt_ff} + 4'd6;
   assign cnt_out   = (cnt >= 4'd8) ? (cnt - 4'd8) : cnt;
   assign mask      = 12'((12'd1 << cnt_out) - 12'd1);

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      line_len_in = line_len_ff;
      bit_buf_in  = bit_buf_ff;
      bit_cnt_in  = bit_cnt_ff;
      q_push      = 1'b0;
      q_entry     = '{byte0: c, byte1: c, two: 1'b0, armored: 1'b0};
      if (accept) begin
         case (phase_ff)
            PH_FIRST: begin
               if (req_data.in_last) begin
                  q_push   = 1'b1;
                  phase_in = PH_PASS;
               end else begin
                  held_in  = c;
                  phase_in = PH_SECOND;
               end
            end
            PH_SECOND: begin
               if (held_ff == CH_DASH && c == CH_DASH) begin
                  phase_in    = PH_HEADER;
                  line_len_in = 8'd2;
               end else begin
                  q_push        = 1'b1;
                  q_entry.byte0 = held_ff;
                  q_entry.two   = 1'b1;
                  phase_in      = PH_PASS;
               end
            end
            PH_PASS: begin
               q_push = 1'b1;
            end
            PH_HEADER: begin
               if (c == CH_LF) begin
                  if (line_len_ff == 8'd0) begin
                     phase_in = PH_DECODE;
                  end
                  line_len_in = 8'd0;
               end else if (line_len_ff >= 8'(LINE_LIMIT)) begin
                  phase_in = PH_HALT;
               end else begin
                  line_len_in = line_len_ff + 8'd1;
               end
            end
            PH_DECODE: begin
               if (sx.hit) begin
                  if (cnt >= 4'd8) begin
                     q_push          = 1'b1;
                     q_entry.byte0   = 8'(acc >> cnt_out);
                     q_entry.armored = 1'b1;
                  end
                  bit_buf_in = 6'(acc & mask);
                  bit_cnt_in = 3'(cnt_out);
               end
            end
            default: begin
               phase_in = PH_HALT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_FIRST;
         held_ff     <= 8'd0;
         line_len_ff <= 8'd0;
         bit_buf_ff  <= 6'd0;
         bit_cnt_ff  <= 3'd0;
      end else begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         line_len_ff <= line_len_in;
         bit_buf_ff  <= bit_buf_in;
         bit_cnt_ff  <= bit_cnt_in;
      end
   end

endmodule

[rtl/ab64d_queue.sv]
// Short FIFO between front and back ends, one entry per producing input word.
// Depends on ab64d_pkg.
module ab64d_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ab64d_pkg::entry_type push_entry,
   input  logic                 pop,
   output ab64d_pkg::entry_type head,
   output ab64d_pkg::qstat_type stat
);
   import ab64d_pkg::*;

   entry_type         entries_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.ready     = (count_ff != QCNT_W'(QDEPTH));
   assign stat.not_empty = (count_ff != '0);
   assign do_push        = push && stat.ready;
   assign do_pop         = pop && stat.not_empty;
   assign head           = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/ab64d_back.sv]
// Back end: drains queue entries one byte per cycle, unless rsp_ready stalls, into the output register.
// Numbers each byte and flags the last of each run. Depends on ab64d_pkg.
module ab64d_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ab64d_pkg::entry_type head,
   input  logic                 head_valid,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ab64d_pkg::rsp_type   rsp_data
);
   import ab64d_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic [31:0] byte_count_ff, byte_count_in;
   logic        sel_ff, sel_in;
   logic        slot, load, final_byte;

   assign slot       = !rsp_valid_ff || rsp_ready;
   assign load       = slot && head_valid;
   assign final_byte = !head.two || sel_ff;
   assign pop        = load && final_byte;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      byte_count_in = byte_count_ff;
      sel_in        = sel_ff;
      if (slot) begin
         rsp_valid_in = head_valid;
      end
      if (load) begin
         rsp_data_in.out_byte    = sel_ff ? head.byte1 : head.byte0;
         rsp_data_in.byte_index  = byte_count_ff;
         rsp_data_in.is_armored  = head.armored;
         rsp_data_in.last_of_run = final_byte;
         byte_count_in           = byte_count_ff + 32'd1;
         sel_in                  = !final_byte;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         byte_count_ff <= 32'd0;
         sel_ff        <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         byte_count_ff <= byte_count_in;
         sel_ff        <= sel_in;
      end
   end

endmodule

[rtl/armored_base64_stream_decoder_top.sv]
// Armored Base64 stream decoder top: front end, 4-entry queue, back end; uses ab64d_pkg.
// A word accepted by the front end is written into the queue, then loaded into the output
// register when it has room, from which the byte it produced is taken.
// Throughput: one input word per cycle, stalled only while the queue is full; one result
// per cycle unless rsp_ready stalls; the mode-decision pass-through pair gives two results.
// Reset is synchronous; it returns the mode to awaiting the first byte and empties the queue.
module armored_base64_stream_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ab64d_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ab64d_pkg::rsp_type rsp_data
);
   import ab64d_pkg::*;

   logic      q_push, q_pop;
   entry_type q_entry, q_head;
   qstat_type q_stat;

   ab64d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_ready   (q_stat.ready),
      .q_push    (q_push),
      .q_entry   (q_entry)
   );

   ab64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   ab64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_valid (q_stat.not_empty),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // second byte of a pair follows without a gap
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |=> rsp_valid)
      else $error("second byte of pair missing");

   // only pass-through produces two-byte runs
   a_pair_plain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |-> !rsp_data.is_armored)
      else $error("armored two-byte run");

   a_push_pair_plain: assert property (@(posedge clock) disable iff (reset)
      q_push && q_entry.two |-> !q_entry.armored && q_stat.ready)
      else $error("bad pair push");

endmodule
